// File: sv/rgb_to_hsv_convert_defines.svh
// Assertion macros shared by the color conversion block.
`ifndef RGB_TO_HSV_CONVERT_DEFINES_SVH
`define RGB_TO_HSV_CONVERT_DEFINES_SVH
`ifndef SYNTH
// Check that a condition implies another at the same clock edge.
`define RHC_ASSERT_IMPLY(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("rhc assertion failed");
// Check that a condition implies another at the next clock edge.
`define RHC_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("rhc assertion failed");
`else
`define RHC_ASSERT_IMPLY(label, clk, rst, cond, expr)
`define RHC_ASSERT_NEXT(label, clk, rst, cond, expr)
`endif
`endif

// File: sv/rhc_pkg.sv
// Shared types and constants of the RGB to HSV converter.
package rhc_pkg;

   localparam int ChanW = 8;
   localparam int HueW  = 13;
   localparam int QuoW  = 10;
   localparam int NumW  = 18;
   localparam int SectW = 2;

   localparam logic [SectW-1:0] SectRed   = 2'd0;
   localparam logic [SectW-1:0] SectGreen = 2'd1;
   localparam logic [SectW-1:0] SectBlue  = 2'd2;

   localparam logic [NumW-1:0] HueScaleNum = NumW'(960);
   localparam logic [HueW-1:0] HueSector1  = HueW'(1920);
   localparam logic [HueW-1:0] HueSector2  = HueW'(3840);
   localparam logic [HueW-1:0] HueTurn     = HueW'(5760);

   typedef struct packed {
      logic [ChanW-1:0] brightness;
      logic [ChanW-1:0] diff;
      logic [SectW-1:0] sector;
      logic             neg;
      logic [ChanW-1:0] mag;
   } pix_type;

endpackage

// File: sv/rhc_front.sv
// Front end: accept a pixel, find max, min and hue sector, and register it.
module rhc_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [rhc_pkg::ChanW-1:0]    req_red,
   input  logic [rhc_pkg::ChanW-1:0]    req_green,
   input  logic [rhc_pkg::ChanW-1:0]    req_blue,
   input  logic                         q_full,
   output logic                         q_push,
   output rhc_pkg::pix_type             q_data
);

   logic             valid_ff, valid_in;
   rhc_pkg::pix_type pix_ff, pix_in;
   logic [rhc_pkg::ChanW-1:0] mx, mn, opa, opb;
   logic             fire;

   always_comb begin
      mx = req_red;
      if (req_green > mx) mx = req_green;
      if (req_blue > mx) mx = req_blue;
      mn = req_red;
      if (req_green < mn) mn = req_green;
      if (req_blue < mn) mn = req_blue;

      // Ties go to red, then green.
      if (req_red == mx) begin
         pix_in.sector = rhc_pkg::SectRed;
         opa = req_green;
         opb = req_blue;
      end else if (req_green == mx) begin
         pix_in.sector = rhc_pkg::SectGreen;
         opa = req_blue;
         opb = req_red;
      end else begin
         pix_in.sector = rhc_pkg::SectBlue;
         opa = req_red;
         opb = req_green;
      end
      pix_in.brightness = mx;
      pix_in.diff       = mx - mn;
      pix_in.neg        = opb > opa;
      pix_in.mag        = pix_in.neg ? (opb - opa) : (opa - opb);
   end

   assign busy     = valid_ff && q_full;
   assign fire     = start && !busy;
   assign q_push   = valid_ff && !q_full;
   assign q_data   = pix_ff;
   assign valid_in = fire ? 1'b1 : (q_push ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         pix_ff <= pix_in;
      end
   end

endmodule

// File: sv/rhc_queue.sv
// Two-entry queue between the classifier and the divider pipeline.
module rhc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rhc_pkg::pix_type push_data,
   output logic             full,
   output logic             valid,
   output rhc_pkg::pix_type head,
   input  logic             pop
);

   rhc_pkg::pix_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full  = count_ff == 2'd2;
   assign valid = count_ff != 2'd0;
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = (pop && valid) ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop && valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: sv/rhc_back.sv
// Back end: pipelined restoring dividers for saturation and hue, then output.
module rhc_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   input  rhc_pkg::pix_type             q_head,
   output logic                         q_pop,
   output logic                         rsp_strobe,
   output logic [rhc_pkg::HueW-1:0]     rsp_hue,
   output logic [rhc_pkg::ChanW-1:0]    rsp_saturation,
   output logic [rhc_pkg::ChanW-1:0]    rsp_brightness
);

   localparam int QuoW  = rhc_pkg::QuoW;
   localparam int NumW  = rhc_pkg::NumW;
   localparam int ChanW = rhc_pkg::ChanW;
   localparam int HueW  = rhc_pkg::HueW;

   typedef struct packed {
      logic                     zero;
      logic                     neg;
      logic [rhc_pkg::SectW-1:0] sector;
      logic [ChanW-1:0]         brightness;
      logic [NumW-1:0]          sat_rem;
      logic [ChanW-1:0]         sat_den;
      logic [QuoW-1:0]          sat_quo;
      logic [NumW-1:0]          hue_rem;
      logic [ChanW-1:0]         hue_den;
      logic [QuoW-1:0]          hue_quo;
   } stage_type;

   stage_type stg_ff  [QuoW+1];
   stage_type stg_in  [QuoW+1];
   logic [QuoW:0] vld_ff, vld_in;

   logic             out_vld_ff;
   logic [HueW-1:0]  out_hue_ff, out_hue_in;
   logic [ChanW-1:0] out_sat_ff, out_sat_in;
   logic [ChanW-1:0] out_bri_ff;
   logic [HueW-1:0]  base, corr;
   stage_type        last;

   assign q_pop = q_valid;

   // Load the numerators: 255 * diff over max, 960 * |d| over diff.
   always_comb begin
      stg_in[0].zero       = q_head.diff == '0;
      stg_in[0].neg        = q_head.neg;
      stg_in[0].sector     = q_head.sector;
      stg_in[0].brightness = q_head.brightness;
      stg_in[0].sat_rem    = NumW'({q_head.diff, {ChanW{1'b0}}}) - NumW'(q_head.diff);
      stg_in[0].sat_den    = q_head.brightness;
      stg_in[0].sat_quo    = '0;
      stg_in[0].hue_rem    = NumW'(q_head.mag) * rhc_pkg::HueScaleNum;
      stg_in[0].hue_den    = q_head.diff;
      stg_in[0].hue_quo    = '0;
      vld_in[0]            = q_valid;
   end

   // One quotient bit per stage, most significant first.
   for (genvar i = 0; i < QuoW; i++) begin : g_step
      logic [NumW-1:0] sat_sh, hue_sh;
      logic            sat_ge, hue_ge;
      always_comb begin
         sat_sh = NumW'(stg_ff[i].sat_den) << (QuoW - 1 - i);
         hue_sh = NumW'(stg_ff[i].hue_den) << (QuoW - 1 - i);
         sat_ge = stg_ff[i].sat_rem >= sat_sh;
         hue_ge = stg_ff[i].hue_rem >= hue_sh;
         stg_in[i+1] = stg_ff[i];
         if (sat_ge) begin
            stg_in[i+1].sat_rem = stg_ff[i].sat_rem - sat_sh;
         end
         if (hue_ge) begin
            stg_in[i+1].hue_rem = stg_ff[i].hue_rem - hue_sh;
         end
         stg_in[i+1].sat_quo[QuoW-1-i] = sat_ge;
         stg_in[i+1].hue_quo[QuoW-1-i] = hue_ge;
         vld_in[i+1] = vld_ff[i];
      end
   end

   // Place the quotient in its sector; a negative offset rounds away from zero.
   always_comb begin
      last = stg_ff[QuoW];
      case (last.sector)
         rhc_pkg::SectRed:   base = last.neg ? rhc_pkg::HueTurn : '0;
         rhc_pkg::SectGreen: base = rhc_pkg::HueSector1;
         rhc_pkg::SectBlue:  base = rhc_pkg::HueSector2;
         default:            base = '0;
      endcase
      corr = HueW'(last.hue_quo) + HueW'(last.hue_rem != '0);
      if (last.zero) begin
         out_hue_in = '0;
         out_sat_in = '0;
      end else begin
         out_hue_in = last.neg ? (base - corr) : (base + HueW'(last.hue_quo));
         out_sat_in = last.sat_quo[ChanW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         vld_ff     <= vld_in;
         out_vld_ff <= vld_ff[QuoW];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i <= QuoW; i++) begin
         stg_ff[i] <= stg_in[i];
      end
      out_hue_ff <= out_hue_in;
      out_sat_ff <= out_sat_in;
      out_bri_ff <= last.brightness;
   end

   assign rsp_strobe     = out_vld_ff;
   assign rsp_hue        = out_hue_ff;
   assign rsp_saturation = out_sat_ff;
   assign rsp_brightness = out_bri_ff;

endmodule

// File: sv/rgb_to_hsv_convert.sv
// RGB to HSV converter top level: classifier, queue and divider pipeline.
// Each item passes the front register, queue, divider stages and output register.
// Throughput: one item per cycle; the ten-stage divider pipeline sets the latency.
// The receiver cannot stall, so the queue never fills and busy stays low in use.
// Reset (synchronous, active high) drops every item in flight; no other state.
`include "rgb_to_hsv_convert_defines.svh"
module rgb_to_hsv_convert (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [rhc_pkg::ChanW-1:0]    req_red,
   input  logic [rhc_pkg::ChanW-1:0]    req_green,
   input  logic [rhc_pkg::ChanW-1:0]    req_blue,
   output logic                         rsp_strobe,
   output logic [rhc_pkg::HueW-1:0]     rsp_hue,
   output logic [rhc_pkg::ChanW-1:0]    rsp_saturation,
   output logic [rhc_pkg::ChanW-1:0]    rsp_brightness
);

   // Front to queue: push each classified item when there is room.
   logic             q_full;
   logic             q_push;
   rhc_pkg::pix_type q_data;

   // Queue to back: the back end takes the head item every cycle it is there.
   logic             q_valid;
   logic             q_pop;
   rhc_pkg::pix_type q_head;

   rhc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_red   (req_red),
      .req_green (req_green),
      .req_blue  (req_blue),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_data)
   );

   rhc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .full      (q_full),
      .valid     (q_valid),
      .head      (q_head),
      .pop       (q_pop)
   );

   rhc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .rsp_strobe     (rsp_strobe),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_brightness (rsp_brightness)
   );

   // A grey or black pixel carries no hue.
   `RHC_ASSERT_IMPLY(a_grey_hue, clock, reset, rsp_strobe && rsp_saturation == '0, rsp_hue == '0)
   // Hue stays inside one full turn.
   `RHC_ASSERT_IMPLY(a_hue_range, clock, reset, rsp_strobe, rsp_hue < rhc_pkg::HueTurn)
   // A black pixel has no saturation.
   `RHC_ASSERT_IMPLY(a_black_sat, clock, reset, rsp_strobe && rsp_brightness == '0, rsp_saturation == '0)
   // The back end drains the queue every cycle, so a full queue never lasts.
   `RHC_ASSERT_NEXT(a_queue_drain, clock, reset, q_full, !q_full)

endmodule

// File: test/rgb_to_hsv_convert_test.sv
// Self-checking testbench for the RGB to HSV pixel converter.
`timescale 1ns / 1ps
module rgb_to_hsv_convert_test;

   localparam int ChanW = rhc_pkg::ChanW;
   localparam int HueW  = rhc_pkg::HueW;
   localparam int SectW = rhc_pkg::SectW;

   // Stop a hung run long after the slowest correct one would have finished.
   localparam int CycleLimit = 200000;
   localparam int MaxReports = 10;
   // Edges to let pass at the end, after the last expected result has come back.
   localparam int SettleCycles = 40;

   typedef struct packed {
      logic [HueW-1:0]  hue;
      logic [ChanW-1:0] saturation;
      logic [ChanW-1:0] brightness;
   } hsv_type;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   logic [ChanW-1:0] req_red;
   logic [ChanW-1:0] req_green;
   logic [ChanW-1:0] req_blue;
   logic             rsp_strobe;
   logic [HueW-1:0]  rsp_hue;
   logic [ChanW-1:0] rsp_saturation;
   logic [ChanW-1:0] rsp_brightness;

   // Expected HSV results, oldest first.
   hsv_type hsv_expected_q[$];
   hsv_type hsv_oldest;
   int      fault_count;
   int      cycle_count;
   // Chance, in percent, that the sender extends its idle time before an item.
   int      sender_idle_pct;

   rgb_to_hsv_convert u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .rsp_strobe     (rsp_strobe),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_brightness (rsp_brightness)
   );

   always #5 clock = ~clock;

   // Compute the HSV triple for one pixel. Hue is in sixteenths of a degree.
   function automatic hsv_type predict_hsv(input logic [ChanW-1:0] red,
                                           input logic [ChanW-1:0] green,
                                           input logic [ChanW-1:0] blue);
      int               top;
      int               bottom;
      int               diff;
      int               sat;
      int               num;
      int               hue;
      logic [SectW-1:0] sector;
      hsv_type          res;
      top = red;
      if (green > top) top = green;
      if (blue > top) top = blue;
      bottom = red;
      if (green < bottom) bottom = green;
      if (blue < bottom) bottom = blue;
      diff = top - bottom;
      // A black pixel has no saturation; avoid the divide by zero.
      sat = (top == 0) ? 0 : (255 * diff) / top;
      if (sat == 0 || diff == 0) begin
         // Grey pixel: hue is defined as zero.
         hue = 0;
      end else begin
         // Pick the sector of the largest channel; ties favor red, then green.
         if (red == top) begin
            sector = rhc_pkg::SectRed;
            num = int'(green) - int'(blue);
         end else if (green == top) begin
            sector = rhc_pkg::SectGreen;
            num = int'(blue) - int'(red);
         end else begin
            sector = rhc_pkg::SectBlue;
            num = int'(red) - int'(green);
         end
         num = 960 * (2 * int'(sector) * diff + num);
         // Round toward minus infinity, also for a negative numerator.
         if (num >= 0) hue = num / diff;
         else hue = -((-num + diff - 1) / diff);
         // Wrap a negative hue into one full turn.
         if (hue < 0) hue = hue + 5760;
      end
      res.hue        = hue[HueW-1:0];
      res.saturation = sat[ChanW-1:0];
      res.brightness = top[ChanW-1:0];
      return res;
   endfunction

   // Offer one pixel: idle at random first, then hold start until the item is taken.
   task automatic send_pixel(input logic [ChanW-1:0] red,
                             input logic [ChanW-1:0] green,
                             input logic [ChanW-1:0] blue);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         // Drop start and put noise on the data lines; the block must ignore them.
         start     <= 1'b0;
         req_red   <= ChanW'($urandom);
         req_green <= ChanW'($urandom);
         req_blue  <= ChanW'($urandom);
         @(negedge clock);
      end
      start     <= 1'b1;
      req_red   <= red;
      req_green <= green;
      req_blue  <= blue;
      // Advance edge by edge until busy is low at an edge with start high.
      @(posedge clock);
      while (busy) @(posedge clock);
      hsv_expected_q.push_back(predict_hsv(red, green, blue));
   endtask

   // Lower start and hold off until every expected result has come back.
   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (hsv_expected_q.size() != 0) @(posedge clock);
   endtask

   // Build a pixel that favors the corners of the conversion: greys, ties, tiny values.
   task automatic random_pixel(output logic [ChanW-1:0] red,
                               output logic [ChanW-1:0] green,
                               output logic [ChanW-1:0] blue);
      int               mode;
      logic [ChanW-1:0] level;
      mode  = $urandom_range(99);
      level = ChanW'($urandom);
      red   = ChanW'($urandom);
      green = ChanW'($urandom);
      blue  = ChanW'($urandom);
      if (mode >= 90) begin
         red   = ChanW'($urandom_range(3));
         green = ChanW'($urandom_range(3));
         blue  = ChanW'($urandom_range(3));
      end else if (mode >= 78) begin
         // Two channels tie for the maximum; the third sits at or below it.
         case ($urandom_range(2))
            0: begin
               red = level; green = level; blue = ChanW'($urandom_range(level));
            end
            1: begin
               green = level; blue = level; red = ChanW'($urandom_range(level));
            end
            default: begin
               red = level; blue = level; green = ChanW'($urandom_range(level));
            end
         endcase
      end else if (mode >= 68) begin
         red = level; green = level; blue = level;
      end
   endtask

   // Extremes, every sector, ties, black, grey and negative hue wrap.
   task automatic test_directed();
      sender_idle_pct = 0;
      send_pixel(8'd0,   8'd0,   8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd1,   8'd1,   8'd1);
      send_pixel(8'd255, 8'd0,   8'd0);
      send_pixel(8'd0,   8'd255, 8'd0);
      send_pixel(8'd0,   8'd0,   8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd0,   8'd255, 8'd255);
      send_pixel(8'd255, 8'd0,   8'd255);
      send_pixel(8'd255, 8'd0,   8'd1);
      send_pixel(8'd1,   8'd0,   8'd0);
      send_pixel(8'd0,   8'd0,   8'd1);
      send_pixel(8'd255, 8'd254, 8'd0);
      send_pixel(8'd0,   8'd1,   8'd255);
      send_pixel(8'd254, 8'd255, 8'd253);
      send_pixel(8'd170, 8'd85,  8'd255);
      send_pixel(8'd255, 8'd254, 8'd254);
      send_pixel(8'd1,   8'd0,   8'd1);
      send_pixel(8'd85,  8'd170, 8'd0);
      // Hold off until the directed pixels have all come back.
      drain_results();
   endtask

   // Random pixels with the sender idling at the given rate, then drain.
   task automatic test_random(input int count, input int idle_pct);
      logic [ChanW-1:0] red;
      logic [ChanW-1:0] green;
      logic [ChanW-1:0] blue;
      sender_idle_pct = idle_pct;
      repeat (count) begin
         random_pixel(red, green, blue);
         send_pixel(red, green, blue);
      end
      drain_results();
   endtask

   // Compare every strobed result with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (hsv_expected_q.size() == 0) begin
            fault_count++;
            if (fault_count <= MaxReports)
               $display("unexpected result: hue %0d sat %0d val %0d",
                        rsp_hue, rsp_saturation, rsp_brightness);
         end else begin
            hsv_oldest = hsv_expected_q.pop_front();
            if (rsp_hue !== hsv_oldest.hue || rsp_saturation !== hsv_oldest.saturation ||
                rsp_brightness !== hsv_oldest.brightness) begin
               fault_count++;
               if (fault_count <= MaxReports)
                  $display("mismatch: hue %0d/%0d sat %0d/%0d val %0d/%0d (expected/actual)",
                           hsv_oldest.hue, rsp_hue, hsv_oldest.saturation, rsp_saturation,
                           hsv_oldest.brightness, rsp_brightness);
            end
         end
      end
   end

   // Watchdog: end a run that stops making progress.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      start           = 1'b0;
      req_red         = '0;
      req_green       = '0;
      req_blue        = '0;
      fault_count     = 0;
      cycle_count     = 0;
      sender_idle_pct = 0;
      // Hold reset, then release it at a falling edge, away from the rising edge.
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random(250, 0);
      test_random(250, 50);
      test_random(250, 0);
      test_random(250, 17);

      // Let any stray result surface before judging the run.
      repeat (SettleCycles) @(posedge clock);
      if (hsv_expected_q.size() != 0) fault_count++;
      if (fault_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: rgb_to_hsv_convert.f
+incdir+sv
sv/rhc_pkg.sv
sv/rhc_front.sv
sv/rhc_queue.sv
sv/rhc_back.sv
sv/rgb_to_hsv_convert.sv
test/rgb_to_hsv_convert_test.sv
